// File: hw/rtl/msis_pkg.sv
// ----------------------------------------------------------------------------
// msis_pkg
// Shared constants, opcode and service codes and types of the MIPS subset
// instruction step unit.
// ----------------------------------------------------------------------------
package msis_pkg;

	// Default sizes of the data memory and the program counter.
	localparam int DATA_WORDS_DEF = 1024;
	localparam int PC_BITS_DEF    = 16;

	// Fixed field widths of the input and result words.
	localparam int WORD_BITS      = 32;
	localparam int LOAD_ADDR_BITS = 10;
	localparam int OUT_PC_BITS    = 16;
	localparam int REG_ADDR_BITS  = 5;
	localparam int IMM_BITS       = 16;

	// Primary opcodes.
	localparam logic [5:0] OP_SPECIAL = 6'd0;
	localparam logic [5:0] OP_J       = 6'd2;
	localparam logic [5:0] OP_BEQ     = 6'd4;
	localparam logic [5:0] OP_ADDIU   = 6'd9;
	localparam logic [5:0] OP_LW      = 6'd35;
	localparam logic [5:0] OP_SW      = 6'd43;

	// Function codes of the special opcode.
	localparam logic [5:0] FN_ADDU = 6'd33;
	localparam logic [5:0] FN_SLT  = 6'd42;

	// The one instruction word that is a system call.
	localparam logic [WORD_BITS-1:0] SYSCALL_WORD = 32'h0000_000c;

	// Services selected by the value in $v0.
	localparam logic [WORD_BITS-1:0] SVC_EXIT = 32'd10;
	localparam logic [WORD_BITS-1:0] SVC_READ = 32'd5;

	// Architectural registers with a fixed role.
	localparam logic [REG_ADDR_BITS-1:0] REG_ZERO = 5'd0;
	localparam logic [REG_ADDR_BITS-1:0] REG_V0   = 5'd2;
	localparam logic [REG_ADDR_BITS-1:0] REG_A0   = 5'd4;
	localparam logic [REG_ADDR_BITS-1:0] REG_GP   = 5'd28;

	// Configuration register index (byte address bits above the word offset).
	localparam logic CFG_GLOBAL_POINTER = 1'b0;

	// State writes produced by one executed word.
	typedef struct packed {
		logic                     reg_we;
		logic [REG_ADDR_BITS-1:0] reg_addr;
		logic [WORD_BITS-1:0]     reg_data;
		logic                     mem_we;
		logic [IMM_BITS-1:0]      mem_idx;
		logic [WORD_BITS-1:0]     mem_data;
	} msis_wr_t;

	// Status produced by one executed word.
	typedef struct packed {
		logic                 halt_set;
		logic                 print_valid;
		logic [WORD_BITS-1:0] print_value;
		logic                 read_taken;
	} msis_status_t;

endpackage

// File: hw/rtl/msis_channels.sv
// ----------------------------------------------------------------------------
// msis_channels
// Valid/ready channels carrying input words and result words.
// ----------------------------------------------------------------------------
interface msis_in_if;
	import msis_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic [WORD_BITS-1:0]      instruction;
	logic [LOAD_ADDR_BITS-1:0] load_address;
	logic [WORD_BITS-1:0]      load_value;
	logic [WORD_BITS-1:0]      read_value;

	modport source(output valid, mode, instruction, load_address, load_value, read_value,
		input ready);
	modport sink(input valid, mode, instruction, load_address, load_value, read_value,
		output ready);
endinterface

interface msis_out_if;
	import msis_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [OUT_PC_BITS-1:0] executed_pc;
	logic [OUT_PC_BITS-1:0] next_pc;
	logic                   halted;
	logic                   print_valid;
	logic [WORD_BITS-1:0]   print_value;
	logic                   read_taken;

	modport source(output valid, executed_pc, next_pc, halted, print_valid, print_value,
		read_taken, input ready);
	modport sink(input valid, executed_pc, next_pc, halted, print_valid, print_value,
		read_taken, output ready);
endinterface

// File: hw/rtl/msis_regfile.sv
// ----------------------------------------------------------------------------
// msis_regfile
// Thirty-two word register file with one write port and two registered read
// ports, valid bits for the reset value and bypass of a same-edge write.
// ----------------------------------------------------------------------------
module msis_regfile (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        we,
	input  logic [4:0]  waddr,
	input  logic [31:0] wdata,
	input  logic        re,
	input  logic [4:0]  raddr_a,
	input  logic [4:0]  raddr_b,
	output logic [31:0] rdata_a,
	output logic [31:0] rdata_b
);
	import msis_pkg::*;

	localparam int NREGS = 1 << REG_ADDR_BITS;

	logic [WORD_BITS-1:0] regs [NREGS];
	logic [NREGS-1:0]     valid_q;
	logic                 wr_ok;
	logic [WORD_BITS-1:0] mem_a_q;
	logic [WORD_BITS-1:0] mem_b_q;
	logic                 vld_a_q;
	logic                 vld_b_q;
	logic                 fwd_a_q;
	logic                 fwd_b_q;
	logic [WORD_BITS-1:0] fwd_data_q;

	// Register zero is never written, so it always reads as zero.
	assign wr_ok = we && (waddr != REG_ZERO);

	// Valid bits: an entry not yet written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_ok) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// Storage array with registered reads.
	always_ff @(posedge clk) begin
		if (wr_ok) begin
			regs[waddr] <= wdata;
		end
		if (re) begin
			mem_a_q    <= regs[raddr_a];
			mem_b_q    <= regs[raddr_b];
			vld_a_q    <= valid_q[raddr_a];
			vld_b_q    <= valid_q[raddr_b];
			fwd_a_q    <= wr_ok && (waddr == raddr_a);
			fwd_b_q    <= wr_ok && (waddr == raddr_b);
			fwd_data_q <= wdata;
		end
	end

	// A write at the read edge takes precedence over the stored word.
	assign rdata_a = fwd_a_q ? fwd_data_q : (vld_a_q ? mem_a_q : '0);
	assign rdata_b = fwd_b_q ? fwd_data_q : (vld_b_q ? mem_b_q : '0);

endmodule

// File: hw/rtl/msis_dmem.sv
// ----------------------------------------------------------------------------
// msis_dmem
// Data memory with one write port and one registered read port. Indices at
// or beyond the depth read as zero and are never written.
// ----------------------------------------------------------------------------
module msis_dmem #(
	parameter int DATA_WORDS = msis_pkg::DATA_WORDS_DEF
) (
	input  logic        clk,
	input  logic        we,
	input  logic [15:0] widx,
	input  logic [31:0] wdata,
	input  logic        re,
	input  logic [15:0] ridx,
	output logic [31:0] rdata
);
	import msis_pkg::*;

	localparam int AW = $clog2(DATA_WORDS);

	logic [WORD_BITS-1:0] mem [DATA_WORDS];
	logic                 w_in_range;
	logic                 r_in_range;
	logic                 wr_ok;
	logic [WORD_BITS-1:0] rd_q;
	logic                 in_range_q;
	logic                 fwd_q;
	logic [WORD_BITS-1:0] fwd_data_q;

	// Range checks against the configured depth.
	assign w_in_range = {16'd0, widx} < 32'(DATA_WORDS);
	assign r_in_range = {16'd0, ridx} < 32'(DATA_WORDS);
	assign wr_ok      = we && w_in_range;

	// Storage array with a registered read and same-edge write bypass.
	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[widx[AW-1:0]] <= wdata;
		end
		if (re) begin
			rd_q       <= mem[ridx[AW-1:0]];
			in_range_q <= r_in_range;
			fwd_q      <= wr_ok && (widx == ridx);
			fwd_data_q <= wdata;
		end
	end

	assign rdata = !in_range_q ? '0 : (fwd_q ? fwd_data_q : rd_q);

endmodule

// File: hw/rtl/msis_execute.sv
// ----------------------------------------------------------------------------
// msis_execute
// Decode and execution of one held word: the add or compare, the branch and
// jump target, the system call service and the state writes it causes.
// ----------------------------------------------------------------------------
module msis_execute #(
	parameter int PC_BITS = msis_pkg::PC_BITS_DEF
) (
	input  logic                         mode,
	input  logic [31:0]                  instruction,
	input  logic [9:0]                   load_address,
	input  logic [31:0]                  load_value,
	input  logic [31:0]                  read_value,
	input  logic [31:0]                  rs_val,
	input  logic [31:0]                  rt_val,
	input  logic [31:0]                  mem_rdata,
	input  logic [31:0]                  v0_val,
	input  logic [31:0]                  a0_val,
	input  logic [PC_BITS-1:0]           pc,
	input  logic                         halted,
	output msis_pkg::msis_wr_t           wr,
	output msis_pkg::msis_status_t       st,
	output logic [PC_BITS-1:0]           npc
);
	import msis_pkg::*;

	logic [5:0]               op;
	logic [5:0]               fn;
	logic [REG_ADDR_BITS-1:0] rt;
	logic [REG_ADDR_BITS-1:0] rd;
	logic [IMM_BITS-1:0]      imm;
	logic [WORD_BITS-1:0]     simm;

	assign op   = instruction[31:26];
	assign rt   = instruction[20:16];
	assign rd   = instruction[15:11];
	assign fn   = instruction[5:0];
	assign imm  = instruction[15:0];
	assign simm = {{(WORD_BITS - IMM_BITS){imm[IMM_BITS-1]}}, imm};

	// One word: either a data load or one instruction.
	always_comb begin
		wr  = '0;
		st  = '0;
		npc = pc;
		if (mode) begin
			wr.mem_we   = 1'b1;
			wr.mem_idx  = 16'(load_address);
			wr.mem_data = load_value;
		end else if (!halted) begin
			npc = pc + PC_BITS'(1);
			unique case (op)
				OP_SPECIAL: begin
					if (fn == FN_ADDU) begin
						wr.reg_we   = 1'b1;
						wr.reg_addr = rd;
						wr.reg_data = rs_val + rt_val;
					end else if (fn == FN_SLT) begin
						wr.reg_we   = 1'b1;
						wr.reg_addr = rd;
						wr.reg_data = {31'd0, rs_val < rt_val};
					end else if (instruction == SYSCALL_WORD) begin
						if (v0_val == SVC_EXIT) begin
							st.halt_set = 1'b1;
							npc         = pc;
						end else if (v0_val == SVC_READ) begin
							wr.reg_we     = 1'b1;
							wr.reg_addr   = REG_V0;
							wr.reg_data   = read_value;
							st.read_taken = 1'b1;
						end else begin
							st.print_valid = 1'b1;
							st.print_value = a0_val;
						end
					end
				end
				OP_ADDIU: begin
					wr.reg_we   = 1'b1;
					wr.reg_addr = rt;
					wr.reg_data = rs_val + simm;
				end
				OP_J: begin
					npc = instruction[PC_BITS-1:0];
				end
				OP_BEQ: begin
					if (rs_val == rt_val) begin
						npc = pc + simm[PC_BITS-1:0];
					end
				end
				OP_LW: begin
					wr.reg_we   = 1'b1;
					wr.reg_addr = rt;
					wr.reg_data = mem_rdata;
				end
				OP_SW: begin
					wr.mem_we   = 1'b1;
					wr.mem_idx  = imm;
					wr.mem_data = rt_val;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/mips_subset_instruction_step_unit.sv
// ----------------------------------------------------------------------------
// mips_subset_instruction_step_unit
// Executes one word per accepted item: an instruction of a small MIPS subset
// (addu, unsigned slt, addiu, j, beq, lw, sw, syscall) or, in load mode, a
// write of one data memory word. Register file, data memory and operands are
// read at the edge an item is accepted; the item is executed from its stage
// register and its result goes to an output register, so one item is taken
// every cycle while the result side does not stall, and its result word is
// offered from the output register. The rate is set by the single write port
// of the register file and of the data memory, each used at most once per
// item; a write by the preceding item is bypassed into the operands. No
// clearing pass runs after reset. The global pointer register at byte
// address 0 also writes register 28 when written.
// ----------------------------------------------------------------------------
module mips_subset_instruction_step_unit #(
	parameter int DATA_WORDS = msis_pkg::DATA_WORDS_DEF,
	parameter int PC_BITS    = msis_pkg::PC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	msis_in_if.sink     item,
	msis_out_if.source  result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import msis_pkg::*;

	logic                      accept;
	logic                      advance;
	logic                      cfg_we;
	logic                      valid_s1;
	logic                      mode_s1;
	logic [WORD_BITS-1:0]      instr_s1;
	logic [LOAD_ADDR_BITS-1:0] load_address_s1;
	logic [WORD_BITS-1:0]      load_value_s1;
	logic [WORD_BITS-1:0]      read_value_s1;
	logic [PC_BITS-1:0]        pc_q;
	logic                      halt_q;
	logic [WORD_BITS-1:0]      gp_q;
	logic [WORD_BITS-1:0]      v0_q;
	logic [WORD_BITS-1:0]      a0_q;
	logic [WORD_BITS-1:0]      rs_val;
	logic [WORD_BITS-1:0]      rt_val;
	logic [WORD_BITS-1:0]      mem_rdata;
	logic [PC_BITS-1:0]        npc;
	msis_wr_t                  wr;
	msis_status_t              st;
	logic                      commit_reg;
	logic                      rf_we;
	logic [REG_ADDR_BITS-1:0]  rf_waddr;
	logic [WORD_BITS-1:0]      rf_wdata;
	logic                      out_valid_q;

	// Handshake: the stage register empties into the output register.
	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign accept     = item.valid && item.ready;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == CFG_GLOBAL_POINTER);
	assign prdata = (paddr[2] == CFG_GLOBAL_POINTER) ? gp_q : '0;

	// Register file write: configuration or the committing word.
	assign commit_reg = advance && wr.reg_we;
	always_comb begin
		if (cfg_we) begin
			rf_we    = 1'b1;
			rf_waddr = REG_GP;
			rf_wdata = pwdata;
		end else begin
			rf_we    = commit_reg;
			rf_waddr = wr.reg_addr;
			rf_wdata = wr.reg_data;
		end
	end

	msis_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (rf_we),
		.waddr   (rf_waddr),
		.wdata   (rf_wdata),
		.re      (accept),
		.raddr_a (item.instruction[25:21]),
		.raddr_b (item.instruction[20:16]),
		.rdata_a (rs_val),
		.rdata_b (rt_val)
	);

	msis_dmem #(
		.DATA_WORDS (DATA_WORDS)
	) u_dmem (
		.clk   (clk),
		.we    (advance && wr.mem_we),
		.widx  (wr.mem_idx),
		.wdata (wr.mem_data),
		.re    (accept),
		.ridx  (item.instruction[15:0]),
		.rdata (mem_rdata)
	);

	msis_execute #(
		.PC_BITS (PC_BITS)
	) u_execute (
		.mode         (mode_s1),
		.instruction  (instr_s1),
		.load_address (load_address_s1),
		.load_value   (load_value_s1),
		.read_value   (read_value_s1),
		.rs_val       (rs_val),
		.rt_val       (rt_val),
		.mem_rdata    (mem_rdata),
		.v0_val       (v0_q),
		.a0_val       (a0_q),
		.pc           (pc_q),
		.halted       (halt_q),
		.wr           (wr),
		.st           (st),
		.npc          (npc)
	);

	// Stage register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	// Stage register: payload of the accepted word.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1         <= item.mode;
			instr_s1        <= item.instruction;
			load_address_s1 <= item.load_address;
			load_value_s1   <= item.load_value;
			read_value_s1   <= item.read_value;
		end
	end

	// Architectural state: program counter, halt flag, global pointer and
	// copies of $v0 and $a0 for the system call.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			halt_q <= 1'b0;
			gp_q   <= '0;
			v0_q   <= '0;
			a0_q   <= '0;
		end else begin
			if (cfg_we) begin
				gp_q <= pwdata;
			end
			if (advance) begin
				pc_q   <= npc;
				halt_q <= halt_q || st.halt_set;
			end
			if (commit_reg && (wr.reg_addr == REG_V0)) begin
				v0_q <= wr.reg_data;
			end
			if (commit_reg && (wr.reg_addr == REG_A0)) begin
				a0_q <= wr.reg_data;
			end
		end
	end

	// Output register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register: result word.
	always_ff @(posedge clk) begin
		if (advance) begin
			result.executed_pc <= OUT_PC_BITS'(pc_q);
			result.next_pc     <= OUT_PC_BITS'(npc);
			result.halted      <= halt_q || st.halt_set;
			result.print_valid <= st.print_valid;
			result.print_value <= st.print_value;
			result.read_taken  <= st.read_taken;
		end
	end

	assign result.valid = out_valid_q;

`ifndef SYNTH
	// Once set, the halt flag stays set until reset.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag cleared without reset");

	// A halted result never moves the program counter.
	a_halted_pc_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result.halted) |-> (result.next_pc == result.executed_pc))
		else $error("program counter moved after halt");

	// The program counter changes only when a word leaves the stage register.
	a_pc_only_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(pc_q))
		else $error("program counter changed without a committed word");

	// No word is taken while the stage is full and the result is stalled.
	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !result.ready) |-> !item.ready)
		else $error("word accepted into a full stage");
`endif

endmodule

// File: tb/sv/mips_subset_instruction_step_unit_test.sv
// ----------------------------------------------------------------------------
// mips_subset_instruction_step_unit_test
// Self-checking bench for the MIPS subset step unit. A short table of
// hand-built words covers the extremes and the special cases. Random words,
// mostly well-formed instructions, follow under several global pointer
// settings and idling patterns. Each result word is checked against a
// behavioural core model in this bench or a result stated by hand. The exit
// service is saved for the very end, because the core ignores instructions once halted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mips_subset_instruction_step_unit_test;
	import msis_pkg::*;

	localparam int DATA_WORDS    = DATA_WORDS_DEF;
	localparam int QUIET_LIMIT   = 1000;
	localparam int RANDOM_WORDS  = 185;
	localparam int REPORT_LINES  = 200;

	// Address of the global pointer register on the configuration port.
	localparam logic [2:0] GP_ADDR = {CFG_GLOBAL_POINTER, 2'b00};

	// Opcode outside the subset, handled as a no-operation.
	localparam logic [5:0] OP_JAL = 6'd3;

	// Scratch registers used by the directed table.
	localparam logic [REG_ADDR_BITS-1:0] REG_V1 = 5'd3;
	localparam logic [REG_ADDR_BITS-1:0] REG_A1 = 5'd5;
	localparam logic [REG_ADDR_BITS-1:0] REG_A2 = 5'd6;
	localparam logic [REG_ADDR_BITS-1:0] REG_A3 = 5'd7;
	localparam logic [REG_ADDR_BITS-1:0] REG_T0 = 5'd8;
	localparam logic [REG_ADDR_BITS-1:0] REG_T1 = 5'd9;
	localparam logic [REG_ADDR_BITS-1:0] REG_T2 = 5'd10;

	typedef struct packed {
		logic                      mode;
		logic [WORD_BITS-1:0]      instruction;
		logic [LOAD_ADDR_BITS-1:0] load_address;
		logic [WORD_BITS-1:0]      load_value;
		logic [WORD_BITS-1:0]      read_value;
	} step_word_t;

	typedef struct packed {
		logic [OUT_PC_BITS-1:0] executed_pc;
		logic [OUT_PC_BITS-1:0] next_pc;
		logic                   halted;
		logic                   print_valid;
		logic [WORD_BITS-1:0]   print_value;
		logic                   read_taken;
	} step_result_t;

	typedef struct {
		step_word_t   w;
		bit           typed;
		step_result_t want;
	} step_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	msis_in_if  item_if();
	msis_out_if result_if();

	mips_subset_instruction_step_unit dut (
		.clk,
		.arst_n,
		.item    (item_if),
		.result  (result_if),
		.psel,
		.penable,
		.pwrite,
		.paddr,
		.pwdata,
		.prdata,
		.pready
	);

	// Architectural state of the model core.
	logic [WORD_BITS-1:0]   gpr [32];
	logic [OUT_PC_BITS-1:0] pc_q;
	logic [WORD_BITS-1:0]   dmem [DATA_WORDS];
	bit                     dmem_written [DATA_WORDS];
	logic [IMM_BITS-1:0]    written_idx [$];
	bit                     halt_q;

	step_result_t pending_results [$];
	step_row_t    stim_table [$];
	int           tail_start;
	int           mismatch_count;
	int           send_idle_pct;
	int           ready_stall_pct;
	int           quiet_cycles;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Instruction encoders.
	function automatic logic [31:0] enc_r(input logic [4:0] rs, rt, rd, input logic [5:0] fn);
		return {OP_SPECIAL, rs, rt, rd, 5'd0, fn};
	endfunction

	function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs, rt,
		input logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic step_row_t exec_row(input logic [31:0] ins, input logic [31:0] rv);
		step_row_t r;
		r.w = '{mode: 1'b0, instruction: ins, load_address: '0, load_value: '0, read_value: rv};
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic step_row_t load_row(input logic [9:0] addr, input logic [31:0] val);
		step_row_t r;
		r.w = '{mode: 1'b1, instruction: '0, load_address: addr, load_value: val,
			read_value: '0};
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	// Attaches a result that can be stated by hand to a table row.
	function automatic step_row_t known(input step_row_t r, input logic [15:0] epc, npc,
		input logic pv, input logic [31:0] pval, input logic rt);
		r.typed = 1'b1;
		r.want = '{executed_pc: epc, next_pc: npc, halted: 1'b0, print_valid: pv,
			print_value: pval, read_taken: rt};
		return r;
	endfunction

	// Appends one row to the stimulus table.
	function automatic void add_row(input step_row_t r);
		stim_table.insert(stim_table.size(), r);
	endfunction

	function automatic void put_gpr(input logic [4:0] idx, input logic [31:0] val);
		if (idx != REG_ZERO)
			gpr[idx] = val;
	endfunction

	// Data words beyond the memory are dropped.
	function automatic void put_dmem(input logic [15:0] idx, input logic [31:0] val);
		if (idx < DATA_WORDS) begin
			if (!dmem_written[idx[9:0]])
				written_idx.insert(written_idx.size(), idx);
			dmem_written[idx[9:0]] = 1'b1;
			dmem[idx[9:0]] = val;
		end
	endfunction

	// Model of one step of the core: updates the state and returns the result word.
	function automatic step_result_t execute_word(input step_word_t w);
		step_result_t r;
		logic [5:0]  op;
		logic [5:0]  fn;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  rd;
		logic [15:0] imm;
		logic [31:0] simm;
		logic [31:0] a;
		logic [31:0] b;
		r = '0;
		r.executed_pc = pc_q;
		r.next_pc = pc_q;
		op = w.instruction[31:26];
		rs = w.instruction[25:21];
		rt = w.instruction[20:16];
		rd = w.instruction[15:11];
		fn = w.instruction[5:0];
		imm = w.instruction[15:0];
		simm = {{16{imm[15]}}, imm};
		a = gpr[rs];
		b = gpr[rt];
		if (w.mode) begin
			put_dmem({6'd0, w.load_address}, w.load_value);
		end else if (!halt_q) begin
			r.next_pc = pc_q + 16'd1;
			case (op)
				OP_SPECIAL: begin
					if (fn == FN_ADDU) begin
						put_gpr(rd, a + b);
					end else if (fn == FN_SLT) begin
						put_gpr(rd, {31'd0, a < b});
					end else if (w.instruction == SYSCALL_WORD) begin
						if (gpr[REG_V0] == SVC_EXIT) begin
							halt_q = 1'b1;
							r.next_pc = pc_q;
						end else if (gpr[REG_V0] == SVC_READ) begin
							put_gpr(REG_V0, w.read_value);
							r.read_taken = 1'b1;
						end else begin
							r.print_valid = 1'b1;
							r.print_value = gpr[REG_A0];
						end
					end
				end
				OP_ADDIU: put_gpr(rt, a + simm);
				// The target field taken modulo the program counter range.
				OP_J: r.next_pc = w.instruction[15:0];
				// A 16-bit add of the offset is the sign-extended add, wrapped.
				OP_BEQ: begin
					if (a == b)
						r.next_pc = pc_q + imm;
				end
				OP_LW: put_gpr(rt, (imm < DATA_WORDS) ? dmem[imm[9:0]] : 32'd0);
				OP_SW: put_dmem(imm, b);
				default: ;
			endcase
			pc_q = r.next_pc;
		end
		r.halted = halt_q;
		return r;
	endfunction

	// Keeps a word inside the contract: no load from a data word never written, and
	// no exit service until the closing rows.
	function automatic step_word_t legalise(input step_word_t w, input bit exit_ok);
		if (!w.mode && !halt_q) begin
			if (w.instruction[31:26] == OP_LW && w.instruction[15:0] < DATA_WORDS &&
					!dmem_written[w.instruction[9:0]])
				w.instruction[15] = 1'b1;
			if (w.instruction == SYSCALL_WORD && gpr[REG_V0] == SVC_EXIT && !exit_ok)
				w.instruction = enc_i(OP_ADDIU, REG_ZERO, REG_V0, SVC_READ[15:0]);
		end
		return w;
	endfunction

	// Registers with a fixed role come up often so that values meet again.
	function automatic logic [4:0] pick_reg();
		case ($urandom_range(0, 8))
			0: return REG_ZERO;
			1: return REG_V0;
			2: return REG_V1;
			3: return REG_A0;
			4: return REG_A1;
			5: return REG_GP;
			default: return 5'($urandom_range(0, 31));
		endcase
	endfunction

	function automatic step_word_t random_word();
		step_word_t  w;
		int          kind;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  rd;
		logic [15:0] imm;
		logic [31:0] shamt;
		w.mode = 1'b0;
		w.instruction = $urandom;
		w.load_address = 10'($urandom_range(0, 1023));
		w.load_value = $urandom;
		w.read_value = $urandom;
		rs = pick_reg();
		rt = pick_reg();
		rd = pick_reg();
		imm = 16'($urandom_range(0, 65535));
		shamt = 32'($urandom_range(0, 31)) << 6;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			w.mode = 1'b1;
		end else if (kind < 13) begin
			// Raw noise in the instruction word.
		end else if (kind < 27) begin
			w.instruction = enc_r(rs, rt, rd, FN_ADDU) | shamt;
		end else if (kind < 37) begin
			w.instruction = enc_r(rs, rt, rd, FN_SLT) | shamt;
		end else if (kind < 50) begin
			if ($urandom_range(0, 1))
				imm = {{12{imm[3]}}, imm[3:0]};
			w.instruction = enc_i(OP_ADDIU, rs, rt, imm);
		end else if (kind < 55) begin
			// Sets up the service number for a following system call.
			case ($urandom_range(0, 3))
				0, 1: imm = SVC_READ[15:0];
				2: imm = SVC_EXIT[15:0];
				default: ;
			endcase
			w.instruction = enc_i(OP_ADDIU, REG_ZERO, REG_V0, imm);
		end else if (kind < 60) begin
			w.instruction = {OP_J, 26'($urandom)};
		end else if (kind < 70) begin
			if ($urandom_range(0, 2) == 0)
				rt = rs;
			if ($urandom_range(0, 1))
				imm = {{12{imm[3]}}, imm[3:0]};
			w.instruction = enc_i(OP_BEQ, rs, rt, imm);
		end else if (kind < 80) begin
			if (written_idx.size() != 0 && $urandom_range(0, 2) != 0)
				imm = written_idx[$urandom_range(0, written_idx.size() - 1)];
			w.instruction = enc_i(OP_LW, rs, rt, imm);
		end else if (kind < 90) begin
			if ($urandom_range(0, 4) != 0)
				imm = 16'($urandom_range(0, DATA_WORDS - 1));
			w.instruction = enc_i(OP_SW, rs, rt, imm);
		end else if (kind < 97) begin
			w.instruction = SYSCALL_WORD;
		end else begin
			w.instruction = $urandom_range(0, 1) ? {OP_JAL, 26'($urandom)} :
				enc_r(rs, rt, rd, 6'($urandom_range(0, 31)));
		end
		return w;
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got, want);
		if (mismatch_count < REPORT_LINES)
			$display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_word(input step_result_t got, input step_result_t want);
		if (got.executed_pc !== want.executed_pc)
			flag_mismatch("executed_pc", 32'(got.executed_pc), 32'(want.executed_pc));
		if (got.next_pc !== want.next_pc)
			flag_mismatch("next_pc", 32'(got.next_pc), 32'(want.next_pc));
		if (got.halted !== want.halted)
			flag_mismatch("halted", 32'(got.halted), 32'(want.halted));
		if (got.print_valid !== want.print_valid)
			flag_mismatch("print_valid", 32'(got.print_valid), 32'(want.print_valid));
		if (got.print_value !== want.print_value)
			flag_mismatch("print_value", got.print_value, want.print_value);
		if (got.read_taken !== want.read_taken)
			flag_mismatch("read_taken", 32'(got.read_taken), 32'(want.read_taken));
	endtask

	// Offers one word, waits for it to be taken and records what it should produce.
	task automatic send_word(input step_word_t w, input bit typed, input step_result_t want,
		input bit exit_ok);
		step_word_t   v;
		step_result_t predicted;
		v = legalise(w, exit_ok);
		while ($urandom_range(1, 100) <= send_idle_pct) begin
			item_if.valid <= 1'b0;
			@(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.mode <= v.mode;
		item_if.instruction <= v.instruction;
		item_if.load_address <= v.load_address;
		item_if.load_value <= v.load_value;
		item_if.read_value <= v.read_value;
		@(posedge clk);
		while (!item_if.ready)
			@(posedge clk);
		predicted = execute_word(v);
		pending_results.insert(pending_results.size(), typed ? want : predicted);
	endtask

	// Lets the core run dry before a register write or the end of the run.
	task automatic settle();
		item_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes the global pointer, then reads it back.
	task automatic program_gp(input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= GP_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		gpr[REG_GP] = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== value)
			flag_mismatch("global_pointer read back", prdata, value);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Result side: checks each word taken and stalls at random.
	always @(posedge clk) begin
		step_result_t got;
		if (result_if.valid && result_if.ready) begin
			got = '{executed_pc: result_if.executed_pc, next_pc: result_if.next_pc,
				halted: result_if.halted, print_valid: result_if.print_valid,
				print_value: result_if.print_value, read_taken: result_if.read_taken};
			if (pending_results.size() == 0)
				flag_mismatch("result word with none pending, executed_pc",
					32'(got.executed_pc), 32'hxxxx_xxxx);
			else
				check_word(got, pending_results.pop_front());
		end
		result_if.ready <= arst_n && ($urandom_range(1, 100) > ready_stall_pct);
	end

	// Ends a run that stops moving words.
	always @(posedge clk) begin
		if (!arst_n || (item_if.valid && item_if.ready) ||
				(result_if.valid && result_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("mips_subset_instruction_step_unit: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [31:0] gp;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		item_if.valid <= 1'b0;
		item_if.mode <= 1'b0;
		item_if.instruction <= '0;
		item_if.load_address <= '0;
		item_if.load_value <= '0;
		item_if.read_value <= '0;
		mismatch_count = 0;
		send_idle_pct = 0;
		ready_stall_pct = 0;
		for (int i = 0; i < 32; i++)
			gpr[i] = '0;
		for (int i = 0; i < DATA_WORDS; i++) begin
			dmem[i] = '0;
			dmem_written[i] = 1'b0;
		end
		pc_q = '0;
		halt_q = 1'b0;

		// Directed table. With the global pointer at all ones, the program
		// counter runs 0, 1, 2 ... through the execute rows until the branches.
		add_row(known(load_row(10'd0, 32'hFFFF_FFFF), 16'd0, 16'd0, 1'b0, 32'd0, 1'b0));
		add_row(known(load_row(10'd1023, 32'h0), 16'd0, 16'd0, 1'b0, 32'd0, 1'b0));
		// Sign-extended immediate gives all ones in $a0, then printed.
		add_row(known(exec_row(enc_i(OP_ADDIU, REG_ZERO, REG_A0, 16'hFFFF),
			32'd0), 16'd0, 16'd1, 1'b0, 32'd0, 1'b0));
		add_row(known(exec_row(SYSCALL_WORD, 32'd0), 16'd1, 16'd2, 1'b1,
			32'hFFFF_FFFF, 1'b0));
		add_row(exec_row(enc_i(OP_ADDIU, REG_ZERO, REG_V0, SVC_READ[15:0]), 32'd0));
		add_row(known(exec_row(SYSCALL_WORD, 32'hFFFF_FFFF), 16'd3, 16'd4, 1'b0,
			32'd0, 1'b1));
		add_row(exec_row(enc_r(REG_V0, REG_GP, REG_V1, FN_ADDU), 32'd0));
		add_row(exec_row(enc_r(REG_A0, REG_V1, REG_A1, FN_SLT), 32'd0));
		add_row(exec_row(enc_r(REG_V1, REG_A0, REG_A2, FN_SLT), 32'd0));
		// A write to register zero is dropped, so the print below shows zero.
		add_row(exec_row(enc_r(REG_A2, REG_A2, REG_ZERO, FN_ADDU), 32'd0));
		add_row(exec_row(enc_r(REG_ZERO, REG_ZERO, REG_A0, FN_ADDU), 32'd0));
		add_row(known(exec_row(SYSCALL_WORD, 32'd0), 16'd9, 16'd10, 1'b1, 32'd0, 1'b0));
		add_row(exec_row(enc_i(OP_LW, REG_ZERO, REG_A3, 16'd0), 32'd0));
		add_row(exec_row(enc_i(OP_SW, REG_ZERO, REG_V1, 16'd1023), 32'd0));
		add_row(exec_row(enc_i(OP_LW, REG_ZERO, REG_T0, 16'd1023), 32'd0));
		// Data indices beyond the memory: the load gives zero, the store is lost.
		add_row(exec_row(enc_i(OP_LW, REG_ZERO, REG_T1, 16'hFFFF), 32'd0));
		add_row(exec_row(enc_i(OP_SW, REG_ZERO, REG_V1, 16'h0400), 32'd0));
		// Taken branch back by one, untaken branch, jump to the top and wrap.
		add_row(known(exec_row(enc_i(OP_BEQ, REG_ZERO, REG_ZERO, 16'hFFFF),
			32'd0), 16'd15, 16'd14, 1'b0, 32'd0, 1'b0));
		add_row(exec_row(enc_i(OP_BEQ, REG_V1, REG_A1, 16'h7FFF), 32'd0));
		add_row(known(exec_row({OP_J, 26'h3FF_FFFF}, 32'd0), 16'd15,
			16'hFFFF, 1'b0, 32'd0, 1'b0));
		add_row(known(exec_row(enc_i(OP_ADDIU, REG_T2, REG_T2, 16'h7FFF),
			32'd0), 16'hFFFF, 16'd0, 1'b0, 32'd0, 1'b0));
		// Not quite the system call word, and an opcode outside the subset.
		add_row(exec_row(SYSCALL_WORD | 32'h0000_0400, 32'd0));
		add_row(exec_row({OP_JAL, 26'h0}, 32'd0));
		add_row(known(exec_row(enc_i(OP_BEQ, REG_A1, REG_ZERO, 16'h8000),
			32'd0), 16'd2, 16'h8002, 1'b0, 32'd0, 1'b0));
		add_row(known(load_row(10'd512, 32'h8000_0001), 16'h8002, 16'h8002,
			1'b0, 32'd0, 1'b0));
		// Closing rows: exit, then words the halted core must ignore, while a
		// load still writes its data word.
		tail_start = stim_table.size();
		add_row(exec_row(enc_i(OP_ADDIU, REG_ZERO, REG_V0, SVC_EXIT[15:0]), 32'd0));
		add_row(exec_row(SYSCALL_WORD, 32'd0));
		add_row(exec_row(enc_i(OP_ADDIU, REG_A0, REG_A0, 16'd1), 32'd0));
		add_row(load_row(10'd7, 32'h5A5A_A5A5));
		add_row(exec_row(SYSCALL_WORD, 32'hFFFF_FFFF));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		program_gp(32'hFFFF_FFFF);
		for (int i = 0; i < tail_start; i++)
			send_word(stim_table[i].w, stim_table[i].typed, stim_table[i].want, 1'b0);

		// Random phases, each under its own global pointer and idling pattern.
		for (int p = 0; p < 4; p++) begin
			settle();
			case (p)
				0: begin
					send_idle_pct = 0;
					ready_stall_pct = 0;
					gp = 32'h0000_0000;
				end
				1: begin
					send_idle_pct = 53;
					ready_stall_pct = 0;
					gp = $urandom;
				end
				2: begin
					send_idle_pct = 0;
					ready_stall_pct = 53;
					gp = 32'h8000_0000;
				end
				default: begin
					send_idle_pct = 30;
					ready_stall_pct = 30;
					gp = $urandom;
				end
			endcase
			program_gp(gp);
			for (int n = 0; n < RANDOM_WORDS; n++)
				send_word(random_word(), 1'b0, '0, 1'b0);
		end

		for (int i = tail_start; i < stim_table.size(); i++)
			send_word(stim_table[i].w, stim_table[i].typed, stim_table[i].want, 1'b1);

		settle();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("mips_subset_instruction_step_unit: match");
		else
			$display("mips_subset_instruction_step_unit: mismatch");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/msis_pkg.sv
hw/rtl/msis_channels.sv
hw/rtl/msis_regfile.sv
hw/rtl/msis_dmem.sv
hw/rtl/msis_execute.sv
hw/rtl/mips_subset_instruction_step_unit.sv
tb/sv/mips_subset_instruction_step_unit_test.sv
